/* rtl/lc4b6b_pkg.sv */
// Shared types, code table and helpers for the 4b6b line-code encoder.
package lc4b6b_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned NibW  = 4;
  localparam int unsigned CodeW = 6;

  // 4b6b code table, indexed by nibble value
  localparam logic [CodeW-1:0] CodeTable [16] = '{
    6'h15, 6'h31, 6'h32, 6'h23, 6'h34, 6'h25, 6'h26, 6'h16,
    6'h1A, 6'h19, 6'h2A, 6'h0B, 6'h2C, 6'h0D, 6'h0E, 6'h1C
  };

  // One queued job: the one or two output bytes caused by one input word
  typedef struct packed {
    logic [ByteW-1:0] first_byte;
    logic [ByteW-1:0] second_byte;
    logic             has_second;
    logic             msg_last;
  } job_t;

  function automatic logic [CodeW-1:0] code_of(input logic [NibW-1:0] nib);
    return CodeTable[nib];
  endfunction

endpackage

/* rtl/lc4b6b_front.sv */
// Front end: accept input words, map nibbles and pack them into output-byte jobs.
module lc4b6b_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            stall_o,
  input  logic [lc4b6b_pkg::ByteW-1:0]    data_byte_i,
  input  logic                            is_last_i,
  output logic                            push_o,
  output lc4b6b_pkg::job_t                job_o,
  input  logic                            full_i
);
  import lc4b6b_pkg::*;

  logic                 held_q, held_d;
  logic [NibW-1:0]      pend_q, pend_d;
  logic [2*CodeW-1:0]   codes;

  assign codes   = {code_of(data_byte_i[7:4]), code_of(data_byte_i[3:0])};
  assign stall_o = full_i;
  assign push_o  = valid_i && !full_i;

  always_comb begin
    job_o.msg_last = is_last_i;
    if (held_q) begin
      // four bits held: two full bytes, nothing left over
      job_o.first_byte  = {pend_q, codes[11:8]};
      job_o.second_byte = codes[7:0];
      job_o.has_second  = 1'b1;
      held_d            = 1'b0;
    end else begin
      // nothing held: one byte, four bits left; flush them padded on the last word
      job_o.first_byte  = codes[11:4];
      job_o.second_byte = {codes[3:0], {NibW{1'b0}}};
      job_o.has_second  = is_last_i;
      held_d            = !is_last_i;
    end
    pend_d = codes[3:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 1'b0;
      pend_q <= '0;
    end else if (push_o) begin
      held_q <= held_d;
      pend_q <= pend_d;
    end
  end

  a_last_clears_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && is_last_i) |=> !held_q)
    else $error("held bits survive the last word of a message");

endmodule

/* rtl/lc4b6b_fifo.sv */
// Short job queue between front end and back end.
module lc4b6b_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lc4b6b_pkg::job_t job_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output lc4b6b_pkg::job_t job_o
);
  import lc4b6b_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign job_o   = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= bump(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= bump(rd_ptr_q);
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("job queue underflow");

endmodule

/* rtl/lc4b6b_back.sv */
// Back end: serialise queued jobs into output bytes through an output register.
module lc4b6b_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  lc4b6b_pkg::job_t              job_i,
  output logic                          pop_o,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [lc4b6b_pkg::ByteW-1:0]  code_byte_o,
  output logic                          end_of_message_o
);
  import lc4b6b_pkg::*;

  logic             out_valid_q;
  logic [ByteW-1:0] out_byte_q;
  logic             out_eom_q;
  logic             second_pend_q;
  logic [ByteW-1:0] second_byte_q;
  logic             second_last_q;
  logic             load;

  // output register may take a new word when empty or being drained
  assign load  = !out_valid_q || !stall_i;
  assign pop_o = load && !second_pend_q && !empty_i;

  assign valid_o          = out_valid_q;
  assign code_byte_o      = out_byte_q;
  assign end_of_message_o = out_eom_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      second_pend_q <= 1'b0;
    end else if (load) begin
      if (second_pend_q) begin
        out_valid_q   <= 1'b1;
        second_pend_q <= 1'b0;
      end else begin
        out_valid_q   <= !empty_i;
        second_pend_q <= !empty_i && job_i.has_second;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (second_pend_q) begin
        out_byte_q <= second_byte_q;
        out_eom_q  <= second_last_q;
      end else if (!empty_i) begin
        out_byte_q    <= job_i.first_byte;
        out_eom_q     <= job_i.msg_last && !job_i.has_second;
        second_byte_q <= job_i.second_byte;
        second_last_q <= job_i.msg_last;
      end
    end
  end

  a_second_behind_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    second_pend_q |-> out_valid_q)
    else $error("second byte pending without a first byte on the output");

endmodule

/* rtl/line_code_4b6b_encoder.sv */
// Top level of the 4b6b line-code encoder.
// Each accepted message byte is split into two nibbles, high first, each mapped
// to a 6-bit code word; code words are packed MSB first into output bytes. An
// input word gives one output byte when no code bits are held over (four are
// then held) and two when four were held. On the word flagged is_last any held
// bits go out as one more byte padded with zeros in its low nibble, and the
// final output byte carries end_of_message. Output runs at one byte per cycle
// from a registered output stage while stall_i is low, so that single output
// port sets the rate at which a message goes through. The front end packs
// each word into a job combinationally and writes it to a job queue of
// QueueDepth entries; the input stalls only while that queue is full. With the
// queue empty and the output register free, the first output byte of a word
// passes through the job queue and then the output register. The packing
// state returns to empty after every last word, ready for the next message.
module line_code_4b6b_encoder #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic [lc4b6b_pkg::ByteW-1:0]  data_byte_i,
  input  logic                          is_last_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [lc4b6b_pkg::ByteW-1:0]  code_byte_o,
  output logic                          end_of_message_o
);
  import lc4b6b_pkg::*;

  logic push, pop, full, empty;
  job_t push_job, head_job;

  // accept and pack input words
  lc4b6b_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid_i),
    .stall_o     (stall_o),
    .data_byte_i (data_byte_i),
    .is_last_i   (is_last_i),
    .push_o      (push),
    .job_o       (push_job),
    .full_i      (full)
  );

  // decouple packing from output back-pressure
  lc4b6b_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .job_o   (head_job)
  );

  // drain jobs one byte per cycle while the output is not stalled
  lc4b6b_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .empty_i          (empty),
    .job_i            (head_job),
    .pop_o            (pop),
    .valid_o          (valid_o),
    .stall_i          (stall_i),
    .code_byte_o      (code_byte_o),
    .end_of_message_o (end_of_message_o)
  );

endmodule

/* tb/line_code_4b6b_encoder_test.sv */
// Self-checking testbench for the 4b6b line-code encoder: directed words, backpressure, random messages.
module line_code_4b6b_encoder_test;

  typedef logic [lc4b6b_pkg::ByteW-1:0] octet_t;

  // One packed output byte as the encoder should deliver it
  typedef struct {
    octet_t code;
    logic   eom;
  } coded_t;

  // 6-bit code word for each nibble value, in nibble order
  localparam logic [5:0] SixbTable [16] = '{
    6'h15, 6'h31, 6'h32, 6'h23, 6'h34, 6'h25, 6'h26, 6'h16,
    6'h1A, 6'h19, 6'h2A, 6'h0B, 6'h2C, 6'h0D, 6'h0E, 6'h1C
  };

  // Generous bound: every word with two output bytes, each waiting out the
  // longest receiver stall, plus the longest sender gap, taken many times over
  localparam int CycleLimit = 200000;
  localparam int MaxWait    = 17;
  localparam int SettleCycles = 8;

  logic   clk_i;
  logic   rst_ni;
  logic   valid_i;
  logic   stall_o;
  octet_t data_byte_i;
  logic   is_last_i;
  logic   valid_o;
  logic   stall_i;
  octet_t code_byte_o;
  logic   end_of_message_o;

  line_code_4b6b_encoder dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (valid_i),
    .stall_o          (stall_o),
    .data_byte_i      (data_byte_i),
    .is_last_i        (is_last_i),
    .valid_o          (valid_o),
    .stall_i          (stall_i),
    .code_byte_o      (code_byte_o),
    .end_of_message_o (end_of_message_o)
  );

  // Packing state of the predictor: a held nibble of code bits, or none
  logic [3:0] carry_nibble = 4'h0;
  logic       carry_full   = 1'b0;

  // Output bytes still owed by the encoder, oldest first
  coded_t code_bytes_due [$];

  int  mismatches  = 0;
  int  cycle_count = 0;
  int  hold_left   = 0;
  bit  tx_idle_on  = 1'b1;
  bit  rx_idle_on  = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Stop a hung run; the block must never take this long
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d bytes outstanding", cycle_count,
               code_bytes_due.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Count down a long receiver hold-off, cycle by cycle
  always @(posedge clk_i) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  // Work out the output bytes that one accepted word causes and queue them.
  // With no nibble held, the word gives one byte and leaves four bits held;
  // with a nibble held, it gives two bytes and leaves nothing held. A last
  // word flushes a held nibble as one byte padded with zeros at the low end.
  function automatic void encode_word(input octet_t data, input logic last);
    logic [11:0] pair;
    pair = {SixbTable[data[7:4]], SixbTable[data[3:0]]};
    if (!carry_full) begin
      code_bytes_due.push_back('{code: pair[11:4], eom: 1'b0});
      if (last) begin
        code_bytes_due.push_back('{code: {pair[3:0], 4'h0}, eom: 1'b1});
        carry_full = 1'b0;
      end else begin
        carry_nibble = pair[3:0];
        carry_full   = 1'b1;
      end
    end else begin
      code_bytes_due.push_back('{code: {carry_nibble, pair[11:8]}, eom: 1'b0});
      code_bytes_due.push_back('{code: pair[7:0], eom: last});
      carry_full = 1'b0;
    end
  endfunction

  // Offer one word after a random gap and hold it until accepted. Leave valid
  // high on return, so that a following word with no gap goes straight on.
  task automatic send_word(input octet_t data, input logic last);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, MaxWait) : 0;
    repeat (gap) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i     <= 1'b1;
    data_byte_i <= data;
    is_last_i   <= last;
    do @(posedge clk_i); while (stall_o);
    encode_word(data, last);
  endtask

  // Drop valid and wait until every owed byte has come out
  task automatic wait_all_out();
    valid_i <= 1'b0;
    while (code_bytes_due.size() != 0) @(posedge clk_i);
  endtask

  function automatic octet_t random_octet();
    if ($urandom_range(0, 15) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return octet_t'($urandom_range(0, 255));
  endfunction

  // Receive side: check each delivered byte against the oldest one owed, then
  // draw a fresh stall for the next; a running hold-off overrides the draw.
  initial begin : output_monitor
    int     rx_wait;
    coded_t want;
    rx_wait = 0;
    stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (valid_o && !stall_i) begin
        if (code_bytes_due.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h eom %b", code_byte_o,
                                    end_of_message_o));
        end else begin
          want = code_bytes_due.pop_front();
          if (code_byte_o !== want.code)
            report_mismatch($sformatf("code_byte %02h, want %02h", code_byte_o, want.code));
          if (end_of_message_o !== want.eom)
            report_mismatch($sformatf("end_of_message %b, want %b (byte %02h)",
                                      end_of_message_o, want.eom, want.code));
        end
        rx_wait = rx_idle_on ? $urandom_range(0, MaxWait) : 0;
      end
      if (hold_left > 0) begin
        stall_i <= 1'b1;
      end else if (rx_wait > 0) begin
        stall_i <= 1'b1;
        rx_wait--;
      end else begin
        stall_i <= 1'b0;
      end
    end
  end

  // Every nibble value in both halves of a byte, the all-zero and all-one
  // bytes, and messages ending both with and without a flushed nibble:
  // odd-length messages need the padded byte, even-length ones do not.
  task automatic test_directed_words();
    octet_t msg_bytes [21] = '{
      8'h00,
      8'hFF, 8'h01,
      8'h23, 8'h45, 8'h67, 8'h89,
      8'hAB, 8'hCD, 8'hEF,
      8'h10, 8'h32, 8'h54, 8'h76, 8'h98, 8'hBA, 8'hDC, 8'hFE,
      8'hFF,
      8'h00, 8'h00
    };
    bit msg_ends [21] = '{
      1'b1,
      1'b0, 1'b1,
      1'b0, 1'b0, 1'b0, 1'b1,
      1'b0, 1'b0, 1'b1,
      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
      1'b1,
      1'b0, 1'b1
    };
    for (int i = 0; i < 21; i++) send_word(msg_bytes[i], msg_ends[i]);
  endtask

  // Hold the output off for a long stretch while words keep coming back to
  // back, so that the job queue fills and the input stalls; then pause the
  // sender until everything has drained.
  task automatic test_output_holdoff();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    hold_left  <= 150;
    for (int i = 0; i < 24; i++) send_word(random_octet(), (i % 5 == 4) || (i == 23));
    wait_all_out();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Random messages of mostly short length, the odd long one, each with its
  // own mix of idling on the two sides
  task automatic test_random_messages(input int words);
    int sent;
    int len;
    int mode;
    sent = 0;
    while (sent < words) begin
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 6);
      mode = $urandom_range(0, 9);
      tx_idle_on = (mode != 0) && (mode != 1);
      rx_idle_on = (mode != 0) && (mode != 2);
      for (int i = 0; i < len; i++) send_word(random_octet(), i == len - 1);
      sent += len;
    end
  endtask

  initial begin : run
    valid_i     = 1'b0;
    data_byte_i = '0;
    is_last_i   = 1'b0;
    rst_ni      = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_words();
    test_output_holdoff();
    test_random_messages(255);

    // Drain, then let the block settle so that any stray byte shows
    wait_all_out();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/lc4b6b_pkg.sv
rtl/lc4b6b_front.sv
rtl/lc4b6b_fifo.sv
rtl/lc4b6b_back.sv
rtl/line_code_4b6b_encoder.sv
tb/line_code_4b6b_encoder_test.sv
